/* src/stepped_gradient_span_gen_top_assert.svh */
// Assertion macros used by the span generator back end.
// Each macro expects clk and rst to exist in the module that uses it.
`ifndef STEPPED_GRADIENT_SPAN_GEN_TOP_ASSERT_SVH
`define STEPPED_GRADIENT_SPAN_GEN_TOP_ASSERT_SVH

`define SGSG_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("span generator check failed");

`define SGSG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("span generator sequencing check failed");

`endif

/* src/sgsg_pkg.sv */
// Types and constants of the stepped gradient span generator.
// Used by every module of the block but sgsg_div; depends on nothing.
package sgsg_pkg;

  localparam logic [5:0] MAX_STEPS = 6'd62;
  localparam logic [5:0] RESET_STEPS = 6'd8;
  localparam logic [5:0] WIDTH_BITS = 6'd32;
  localparam logic [5:0] COLOUR_BITS = 6'd8;

  typedef struct packed {
    logic signed [31:0] rect_left;
    logic signed [31:0] rect_right;
    logic signed [31:0] rect_top;
    logic signed [31:0] rect_bottom;
    logic signed [31:0] grad_start;
    logic signed [31:0] grad_stop;
    logic [7:0] start_red;
    logic [7:0] start_green;
    logic [7:0] start_blue;
    logic [7:0] stop_red;
    logic [7:0] stop_green;
    logic [7:0] stop_blue;
  } rect_t;

  typedef struct packed {
    logic signed [31:0] span_left;
    logic signed [31:0] span_right;
    logic signed [31:0] span_top;
    logic signed [31:0] span_bottom;
    logic [7:0] span_red;
    logic [7:0] span_green;
    logic [7:0] span_blue;
    logic span_last;
  } span_t;

  typedef struct packed {
    logic grad;
    logic signed [31:0] left;
    logic signed [31:0] right;
    logic signed [31:0] top;
    logic signed [31:0] bottom;
    logic signed [31:0] gb;
    logic neg;
    logic [31:0] qm;
    logic [5:0] rm;
    logic [5:0] n;
    logic [2:0][7:0] c1;
    logic [2:0][7:0] c2;
    logic [2:0] dneg;
    logic [2:0][8:0] cq0;
    logic [2:0][6:0] cr0;
    logic [2:0][7:0] cinc;
    logic [2:0][6:0] rinc;
  } job_t;

endpackage

/* src/stepped_gradient_span_gen_top.sv */
// Top level of the stepped gradient span generator.
// Depends on sgsg_pkg, sgsg_front, sgsg_fifo and sgsg_back.
//
// A rectangle item is taken when start is high and busy is low. Each span
// appears on span for one cycle with span_valid high; span_last marks the
// final span of a rectangle. The receiver cannot stall, so spans are never
// held back. Empty rectangles yield no span and leave busy low.
// The step count is written through cfg_valid/cfg_ready/cfg_data and is
// sampled when a rectangle is taken. Reset sets it to 8 and empties the
// job queue.
// Rectangles that miss the gradient hold busy until their job enters the
// queue and give a single span once the back end takes the job. A gradient
// rectangle holds busy while the bit-serial divider runs: it divides the
// 32-bit width and then each colour channel, and then the job is queued.
// The back end then walks the bands and emits the spans, overlapped with
// the next rectangle through a two-entry queue.
module stepped_gradient_span_gen_top (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  sgsg_pkg::rect_t rect,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [5:0]      cfg_data,
  output sgsg_pkg::span_t span,
  output logic            span_valid
);

  logic [5:0] step_count;
  sgsg_pkg::job_t job_w;
  sgsg_pkg::job_t job_r;
  logic push;
  logic pop;
  logic full;
  logic empty;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_count <= sgsg_pkg::RESET_STEPS;
    end else if (cfg_valid && cfg_ready) begin
      step_count <= cfg_data;
    end
  end

  sgsg_front u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .rect       (rect),
    .step_count (step_count),
    .job        (job_w),
    .push       (push),
    .full       (full)
  );

  sgsg_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (job_w),
    .full  (full),
    .pop   (pop),
    .rdata (job_r),
    .empty (empty)
  );

  sgsg_back u_back (
    .clk        (clk),
    .rst        (rst),
    .job_in     (job_r),
    .empty      (empty),
    .pop        (pop),
    .span       (span),
    .span_valid (span_valid)
  );

endmodule

/* src/sgsg_div.sv */
// Restoring divider, one quotient bit per cycle, by the step count.
// Depends on nothing beyond its ports.
module sgsg_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [5:0]  nbits,
  input  logic [31:0] num,
  input  logic [5:0]  den,
  output logic        done,
  output logic [31:0] quo,
  output logic [5:0]  rem
);

  logic [5:0] cnt;
  logic [6:0] trial;
  logic       fits;

  always_comb begin
    trial = {rem, quo[31]};
    fits = trial >= {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 6'd0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= nbits;
        quo <= num;
        rem <= 6'd0;
      end else if (cnt != 6'd0) begin
        rem <= fits ? 6'(trial - {1'b0, den}) : trial[5:0];
        quo <= {quo[30:0], fits};
        cnt <= cnt - 6'd1;
        done <= (cnt == 6'd1);
      end
    end
  end

endmodule

/* src/sgsg_front.sv */
// Front end: accepts rectangles, classifies them and runs the divisions.
// Depends on sgsg_pkg and sgsg_div.
module sgsg_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  sgsg_pkg::rect_t rect,
  input  logic [5:0]      step_count,
  output sgsg_pkg::job_t  job,
  output logic            push,
  input  logic            full
);

  typedef enum logic [1:0] {F_IDLE, F_LAUNCH, F_WAIT, F_PUSH} fstate_t;

  fstate_t state;
  logic [1:0] didx;
  logic [1:0] ch;
  logic [31:0] w;
  logic [2:0][7:0] dmag;
  logic [5:0] n_clamp;
  logic signed [32:0] diff;
  logic [2:0][7:0] cs;
  logic [2:0][7:0] ce;
  logic [2:0][8:0] d;
  logic div_start;
  logic div_done;
  logic [31:0] div_quo;
  logic [5:0] div_rem;
  logic [31:0] div_num;
  logic [5:0] div_bits;
  logic [7:0] qn;

  always_comb begin
    if (step_count == 6'd0) begin
      n_clamp = 6'd1;
    end else if (step_count > sgsg_pkg::MAX_STEPS) begin
      n_clamp = sgsg_pkg::MAX_STEPS;
    end else begin
      n_clamp = step_count;
    end
    diff = {rect.grad_stop[31], rect.grad_stop} - {rect.grad_start[31], rect.grad_start};
    cs = {rect.start_blue, rect.start_green, rect.start_red};
    ce = {rect.stop_blue, rect.stop_green, rect.stop_red};
    for (int c = 0; c < 3; c++) begin
      d[c] = {1'b0, ce[c]} - {1'b0, cs[c]};
    end
    ch = didx - 2'd1;
    div_start = (state == F_LAUNCH);
    div_num = (didx == 2'd0) ? w : {dmag[ch], 24'd0};
    div_bits = (didx == 2'd0) ? sgsg_pkg::WIDTH_BITS : sgsg_pkg::COLOUR_BITS;
    qn = div_quo[7:0];
    busy = (state != F_IDLE);
    push = (state == F_PUSH) && !full;
  end

  sgsg_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .nbits (div_bits),
    .num   (div_num),
    .den   (job.n),
    .done  (div_done),
    .quo   (div_quo),
    .rem   (div_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      didx <= 2'd0;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (start) begin
            job.left <= rect.rect_left;
            job.right <= rect.rect_right;
            job.top <= rect.rect_top;
            job.bottom <= rect.rect_bottom;
            job.gb <= rect.grad_start;
            job.n <= n_clamp;
            job.c2 <= ce;
            job.neg <= diff[32];
            w <= diff[32] ? 32'(-diff) : diff[31:0];
            for (int c = 0; c < 3; c++) begin
              job.dneg[c] <= d[c][8];
              dmag[c] <= d[c][8] ? 8'(-d[c]) : d[c][7:0];
            end
            didx <= 2'd0;
            priority if (rect.rect_right <= rect.rect_left) begin
              state <= F_IDLE;
            end else if (rect.grad_stop <= rect.rect_left) begin
              job.grad <= 1'b0;
              job.c1 <= ce;
              state <= F_PUSH;
            end else if (rect.rect_right <= rect.grad_start) begin
              job.grad <= 1'b0;
              job.c1 <= cs;
              state <= F_PUSH;
            end else begin
              job.grad <= 1'b1;
              job.c1 <= cs;
              state <= F_LAUNCH;
            end
          end
        end
        F_LAUNCH: begin
          state <= F_WAIT;
        end
        F_WAIT: begin
          if (div_done) begin
            if (didx == 2'd0) begin
              job.qm <= div_quo;
              job.rm <= div_rem;
            end else begin
              job.cq0[ch] <= {2'b00, qn[7:1]};
              job.cr0[ch] <= {1'b0, div_rem} + (qn[0] ? {1'b0, job.n} : 7'd0);
              job.cinc[ch] <= qn;
              job.rinc[ch] <= {div_rem, 1'b0};
            end
            if (didx == 2'd3) begin
              state <= F_PUSH;
            end else begin
              didx <= didx + 2'd1;
              state <= F_LAUNCH;
            end
          end
        end
        F_PUSH: begin
          if (!full) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

/* src/sgsg_fifo.sv */
// Two-entry queue of prepared jobs between the front and the back end.
// Depends on sgsg_pkg.
module sgsg_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  sgsg_pkg::job_t wdata,
  output logic           full,
  input  logic           pop,
  output sgsg_pkg::job_t rdata,
  output logic           empty
);

  sgsg_pkg::job_t mem [2];
  logic wp;
  logic rp;
  logic [1:0] cnt;

  always_comb begin
    full = (cnt == 2'd2);
    empty = (cnt == 2'd0);
    rdata = mem[rp];
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (pop) begin
        rp <= ~rp;
      end
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

/* src/sgsg_back.sv */
// Back end: walks the band boundaries of one job and emits its spans.
// Depends on sgsg_pkg and the assertion macro header.
`include "stepped_gradient_span_gen_top_assert.svh"

module sgsg_back (
  input  logic           clk,
  input  logic           rst,
  input  sgsg_pkg::job_t job_in,
  input  logic           empty,
  output logic           pop,
  output sgsg_pkg::span_t span,
  output logic           span_valid
);

  typedef enum logic {B_IDLE, B_RUN} bstate_t;

  bstate_t state;
  sgsg_pkg::job_t j;
  logic [5:0] i;
  logic signed [33:0] cur;
  logic [31:0] off;
  logic [5:0] fr;
  logic [2:0][8:0] cq;
  logic [2:0][7:0] cr;

  logic signed [33:0] left_x;
  logic signed [33:0] right_x;
  logic signed [33:0] bnd;
  logic signed [33:0] sr;
  logic signed [33:0] sl;
  logic [33:0] off_x;
  logic [6:0] fr_sum;
  logic carry;
  logic [5:0] fr_next;
  logic [5:0] i_end;
  logic emit;
  logic fin;
  logic [7:0] two_n;
  logic [2:0][7:0] cr_sum;
  logic [2:0] ccar;
  logic [2:0][7:0] cr_next;
  logic [2:0][8:0] cq_next;
  logic [2:0][7:0] colour;

  always_comb begin
    pop = (state == B_IDLE) && !empty;
    left_x = {{2{j.left[31]}}, j.left};
    right_x = {{2{j.right[31]}}, j.right};
    off_x = j.neg ? (34'd0 - {2'b00, off}) : {2'b00, off};
    bnd = {{2{j.gb[31]}}, j.gb} + off_x;
    i_end = j.n + 6'd1;
    if (i <= j.n) begin
      sr = (bnd > right_x) ? right_x : bnd;
    end else begin
      sr = right_x;
    end
    sl = (cur > left_x) ? cur : left_x;
    emit = (sl < sr);
    fin = (sr >= right_x) || (i == i_end);
    fr_sum = {1'b0, fr} + {1'b0, j.rm};
    carry = fr_sum >= {1'b0, j.n};
    fr_next = carry ? 6'(fr_sum - {1'b0, j.n}) : fr_sum[5:0];
    two_n = {1'b0, j.n, 1'b0};
    for (int c = 0; c < 3; c++) begin
      cr_sum[c] = cr[c] + {1'b0, j.rinc[c]};
      ccar[c] = cr_sum[c] >= two_n;
      cr_next[c] = ccar[c] ? cr_sum[c] - two_n : cr_sum[c];
      cq_next[c] = cq[c] + {1'b0, j.cinc[c]} + {8'd0, ccar[c]};
      if (i == 6'd0) begin
        colour[c] = j.c1[c];
      end else if (i == i_end) begin
        colour[c] = j.c2[c];
      end else begin
        colour[c] = j.dneg[c] ? j.c1[c] - cq[c][7:0] : j.c1[c] + cq[c][7:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      span_valid <= 1'b0;
    end else begin
      span_valid <= 1'b0;
      unique case (state)
        B_IDLE: begin
          if (!empty) begin
            j <= job_in;
            if (!job_in.grad) begin
              span.span_left <= job_in.left;
              span.span_right <= job_in.right;
              span.span_top <= job_in.top;
              span.span_bottom <= job_in.bottom;
              span.span_red <= job_in.c1[0];
              span.span_green <= job_in.c1[1];
              span.span_blue <= job_in.c1[2];
              span.span_last <= 1'b1;
              span_valid <= 1'b1;
            end else begin
              i <= 6'd0;
              cur <= {{2{job_in.left[31]}}, job_in.left};
              off <= 32'd0;
              fr <= 6'd0;
              for (int c = 0; c < 3; c++) begin
                cq[c] <= job_in.cq0[c];
                cr[c] <= {1'b0, job_in.cr0[c]};
              end
              state <= B_RUN;
            end
          end
        end
        B_RUN: begin
          span.span_left <= sl[31:0];
          span.span_right <= sr[31:0];
          span.span_top <= j.top;
          span.span_bottom <= j.bottom;
          span.span_red <= colour[0];
          span.span_green <= colour[1];
          span.span_blue <= colour[2];
          span.span_last <= (sr == right_x);
          span_valid <= emit;
          cur <= sr;
          i <= i + 6'd1;
          off <= off + j.qm + {31'd0, carry};
          fr <= fr_next;
          if (i != 6'd0) begin
            cq <= cq_next;
            cr <= cr_next;
          end
          if (fin) begin
            state <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  `SGSG_ASSERT_IMPLIES(a_span_order, span_valid, span.span_left < span.span_right)
  `SGSG_ASSERT_IMPLIES(a_step_bound, state == B_RUN, i <= i_end)
  `SGSG_ASSERT_NEXT(a_single_last, pop && !job_in.grad, span_valid && span.span_last)

endmodule
